// File: src/sol_pkg.sv
// ---------------------------------------------------------------------------
// sol_pkg: shared types for the sorted open list queue
// Opcodes, status codes and the per-cell command group.
// ---------------------------------------------------------------------------
package sol_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SORTED_INSERT = 3'd0,
    OP_PUSH_FRONT    = 3'd1,
    OP_POP_HEAD      = 3'd2,
    OP_FIND          = 3'd3,
    OP_CLEAR         = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL_DROP  = 2'd1,
    ST_POP_EMPTY  = 2'd2
  } status_e;

  // Command broadcast to every cell, already gated by the full/empty checks.
  typedef struct packed {
    logic sorted_ins;
    logic push_front;
    logic pop;
    logic clear;
  } cmd_t;

endpackage

// File: src/sol_cell.sv
// ---------------------------------------------------------------------------
// sol_cell: one slot of the ordered list
// Holds one node and moves it toward the head or the tail with its neighbors.
// ---------------------------------------------------------------------------
module sol_cell #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned COST_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  sol_pkg::cmd_t         cmd_i,
  input  logic                  head_i,
  input  logic [COORD_BITS-1:0] new_x_i,
  input  logic [COORD_BITS-1:0] new_y_i,
  input  logic [COST_BITS-1:0]  new_cost_i,
  input  logic [COORD_BITS-1:0] prev_x_i,
  input  logic [COORD_BITS-1:0] prev_y_i,
  input  logic [COST_BITS-1:0]  prev_cost_i,
  input  logic                  prev_valid_i,
  input  logic                  prev_keep_i,
  input  logic [COORD_BITS-1:0] next_x_i,
  input  logic [COORD_BITS-1:0] next_y_i,
  input  logic [COST_BITS-1:0]  next_cost_i,
  input  logic                  next_valid_i,
  output logic [COORD_BITS-1:0] x_o,
  output logic [COORD_BITS-1:0] y_o,
  output logic [COST_BITS-1:0]  cost_o,
  output logic                  valid_o,
  output logic                  keep_o,
  output logic                  match_o
);
  import sol_pkg::*;

  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [COST_BITS-1:0]  cost_q, cost_d;
  logic                  valid_q, valid_d;
  logic                  keep;

  // Entry stays put on a sorted insert when it and every entry ahead of it
  // cost no more than the new one (push-front can leave the row unsorted).
  assign keep = prev_keep_i && valid_q && (cost_q <= new_cost_i);

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    cost_d  = cost_q;
    valid_d = valid_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.pop) begin
      x_d     = next_x_i;
      y_d     = next_y_i;
      cost_d  = next_cost_i;
      valid_d = next_valid_i;
    end else if ((cmd_i.sorted_ins && !keep && prev_keep_i) ||
                 (cmd_i.push_front && head_i)) begin
      x_d     = new_x_i;
      y_d     = new_y_i;
      cost_d  = new_cost_i;
      valid_d = 1'b1;
    end else if ((cmd_i.sorted_ins && !keep) || cmd_i.push_front) begin
      x_d     = prev_x_i;
      y_d     = prev_y_i;
      cost_d  = prev_cost_i;
      valid_d = prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      cost_q <= cost_d;
    end
  end

  assign x_o     = x_q;
  assign y_o     = y_q;
  assign cost_o  = cost_q;
  assign valid_o = valid_q;
  assign keep_o  = keep;
  assign match_o = valid_q && (x_q == new_x_i) && (y_q == new_y_i);

endmodule

// File: src/sorted_open_list_queue.sv
// ---------------------------------------------------------------------------
// sorted_open_list_queue: bounded cost-ordered open list for path search
// A row of slot cells kept sorted by cost; insert, push-front, pop, find, clear.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Payload (lowest bit first)
//  s_axis   in   tvalid/tready        tdata: in_x, in_y, in_cost; tuser: opcode
//  m_axis   out  tvalid/tready        tdata: head_x, head_y, head_cost, is_empty,
//                                            entry_count, found, status
//
//  Flow: an item updates every cell at the edge it is accepted; its result is
//  composed from the head cell, the count and the registered find hits and is
//  loaded into the output register once that register is free, and is offered
//  from there. With the result side ready, items go back to back.
//  Reset clears the count, all cell valid bits and both handshake flags.
//  Stalls: a held result waits in the output register; the next item is taken
//  while it waits, and a second result waits in the compose stage.
//
module sorted_open_list_queue #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned COST_BITS  = 16,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1),
  localparam int unsigned IN_W      = 2 * COORD_BITS + COST_BITS,
  localparam int unsigned IN_DW     = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W     = 2 * COORD_BITS + COST_BITS + 1 + CNT_W + 1
                                      + sol_pkg::STATUS_W,
  localparam int unsigned OUT_DW    = ((OUT_W + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_DW-1:0]          s_axis_tdata,  // in_x, in_y, in_cost, zero pad
  input  logic [sol_pkg::OP_W-1:0]  s_axis_tuser,  // opcode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_DW-1:0]         m_axis_tdata   // head_x, head_y, head_cost,
                                                   // is_empty, entry_count, found,
                                                   // status, zero pad
);
  import sol_pkg::*;

  // Input unpack
  logic [COORD_BITS-1:0] in_x, in_y;
  logic [COST_BITS-1:0]  in_cost;
  assign in_x    = s_axis_tdata[COORD_BITS-1:0];
  assign in_y    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_cost = s_axis_tdata[IN_W-1:2*COORD_BITS];

  logic accept;
  logic pend_q, pend_d;
  logic out_free;
  logic [CNT_W-1:0] count_q, count_d;
  logic full, empty;
  cmd_t cmd;
  status_e status_d, status_q;
  logic find_d, find_q;
  logic [CAPACITY-1:0] match_w, match_q;

  // Cell row wiring
  logic [COORD_BITS-1:0] cx [CAPACITY];
  logic [COORD_BITS-1:0] cy [CAPACITY];
  logic [COST_BITS-1:0]  cc [CAPACITY];
  logic [CAPACITY-1:0]   cvalid, ckeep;

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  // Take a new item while the compose stage is free or drains this cycle.
  assign s_axis_tready = !pend_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode the opcode and gate by full/empty.
  always_comb begin
    cmd      = '0;
    status_d = ST_OK;
    find_d   = 1'b0;
    count_d  = count_q;
    unique case (s_axis_tuser)
      OP_SORTED_INSERT, OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL_DROP;
        end else begin
          cmd.sorted_ins = (s_axis_tuser == OP_SORTED_INSERT);
          cmd.push_front = (s_axis_tuser == OP_PUSH_FRONT);
          count_d        = count_q + CNT_W'(1);
        end
      end
      OP_POP_HEAD: begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          cmd.pop = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_FIND: begin
        find_d = 1'b1;
      end
      OP_CLEAR: begin
        cmd.clear = 1'b1;
        count_d   = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [COORD_BITS-1:0] px, py, nx, ny;
    logic [COST_BITS-1:0]  pc, nc;
    logic                  pv, pk, nv;

    if (i == 0) begin : g_first
      // The head has no neighbor above: an insert that passes no entry lands here.
      assign px = '0;
      assign py = '0;
      assign pc = '0;
      assign pv = 1'b0;
      assign pk = 1'b1;
    end else begin : g_prev
      assign px = cx[i-1];
      assign py = cy[i-1];
      assign pc = cc[i-1];
      assign pv = cvalid[i-1];
      assign pk = ckeep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign nx = '0;
      assign ny = '0;
      assign nc = '0;
      assign nv = 1'b0;
    end else begin : g_next
      assign nx = cx[i+1];
      assign ny = cy[i+1];
      assign nc = cc[i+1];
      assign nv = cvalid[i+1];
    end

    sol_cell #(
      .COORD_BITS (COORD_BITS),
      .COST_BITS  (COST_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (accept),
      .cmd_i        (cmd),
      .head_i       (i == 0),
      .new_x_i      (in_x),
      .new_y_i      (in_y),
      .new_cost_i   (in_cost),
      .prev_x_i     (px),
      .prev_y_i     (py),
      .prev_cost_i  (pc),
      .prev_valid_i (pv),
      .prev_keep_i  (pk),
      .next_x_i     (nx),
      .next_y_i     (ny),
      .next_cost_i  (nc),
      .next_valid_i (nv),
      .x_o          (cx[i]),
      .y_o          (cy[i]),
      .cost_o       (cc[i]),
      .valid_o      (cvalid[i]),
      .keep_o       (ckeep[i]),
      .match_o      (match_w[i])
    );
  end

  // Compose stage: pend_q marks that cells hold a finished update whose result
  // has not yet been moved into the output register.
  always_comb begin
    pend_d = pend_q;
    if (pend_q && out_free) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      count_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Per-item side info, sampled with the item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      find_q   <= find_d;
      match_q  <= match_w;
    end
  end

  // Output register
  logic [OUT_W-1:0] out_fields;
  logic [OUT_W-1:0] out_q;
  logic             out_valid_q;

  always_comb begin
    if (empty) begin
      out_fields = {status_q, find_q && (|match_q), count_q, 1'b1,
                    {COST_BITS{1'b0}}, {COORD_BITS{1'b0}}, {COORD_BITS{1'b0}}};
    end else begin
      out_fields = {status_q, find_q && (|match_q), count_q, 1'b0,
                    cc[0], cy[0], cx[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Cells are only rewritten when a new item is taken, which happens no
  // earlier than the cycle the pending result moves here, so the head read
  // below still reflects the pending item.
  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      out_q <= out_fields;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DW'(out_q);

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cvalid[0] == (count_q != '0))
    else $error("head cell valid disagrees with count");

  a_tail_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cvalid[CAPACITY-1] == (count_q == CNT_W'(CAPACITY)))
    else $error("tail cell valid disagrees with count");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == OP_CLEAR) |=> (count_q == '0) && (cvalid == '0))
    else $error("clear left entries behind");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == OP_POP_HEAD && !empty)
      |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not drop one entry");

endmodule
